// ===== rtl/dspg_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the stepper pulse generator.
`default_nettype none

package dspg_pkg;

    localparam int TIME_W    = 48;          // time stamp width, microseconds
    localparam int RATE_W    = 21;          // signed step rate width, 1/16 Hz
    localparam int MAG_W     = RATE_W - 1;  // rate magnitude and clamp width
    localparam int MHP_W     = 16;          // minimum half period width
    localparam int HP_W      = 24;          // half period and divisor width
    localparam int CFG_W     = 20;          // widest configuration register
    localparam int CFG_IDX_W = 2;

    // radix-4 divider: two quotient bits per cycle
    localparam int HP_PAIRS   = HP_W / 2;
    localparam int TIME_PAIRS = TIME_W / 2;
    localparam int CNT_W      = $clog2(TIME_PAIRS);

    // 8e6 = 500000 Hz expressed against a rate in 1/16 Hz
    localparam logic [HP_W-1:0]  HP_NUM       = HP_W'(8000000);
    localparam logic [MAG_W-1:0] MAX_RATE_RST = MAG_W'(80000);
    localparam logic [MHP_W-1:0] MIN_HP_RST   = MHP_W'(100);

    typedef enum logic [1:0] {
        K_TICK   = 2'd0,
        K_CMD    = 2'd1,
        K_ENABLE = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RATE  = 2'd0,
        CFG_MIN_HP    = 2'd1,
        CFG_LEFT_POL  = 2'd2,
        CFG_RIGHT_POL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic accept;     // latch the input word
        logic load;       // set up divider for the current channel
        logic div_step;   // two quotient bits
        logic store;      // write back the division result
        logic load_out;   // capture levels into the output register
        logic ch;         // 0 left, 1 right
        logic op_time;    // 1 tick catch-up, 0 half period
    } t_dp_cmd;

    typedef struct packed {
        logic skip;       // nothing to divide for this channel
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/dspg_dp.sv =====
// Datapath: configuration, channel state, shared radix-4 divider and output register.
`default_nettype none

module dspg_dp import dspg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic [1:0]               i_kind,
    input  logic [TIME_W-1:0]        i_now_us,
    input  logic signed [RATE_W-1:0] i_left_rate,
    input  logic signed [RATE_W-1:0] i_right_rate,
    input  logic                     i_enable_request,
    output logic                     o_left_step,
    output logic                     o_right_step,
    output logic                     o_left_dir,
    output logic                     o_right_dir,
    output logic                     o_left_enable_level,
    output logic                     o_right_enable_level
);

    function automatic logic signed [RATE_W-1:0] clamp_rate(
        input logic signed [RATE_W-1:0] r,
        input logic [MAG_W-1:0]         lim
    );
        logic signed [RATE_W:0] rx;
        logic signed [RATE_W:0] lp;
        logic signed [RATE_W:0] ln;
        rx = {r[RATE_W-1], r};
        lp = {2'b00, lim};
        ln = -lp;
        if (rx > lp) begin
            return lp[RATE_W-1:0];
        end else if (rx < ln) begin
            return ln[RATE_W-1:0];
        end else begin
            return r;
        end
    endfunction

    function automatic logic [MAG_W-1:0] rate_mag(input logic signed [RATE_W-1:0] r);
        logic signed [RATE_W-1:0] neg;
        neg = -r;
        return r[RATE_W-1] ? neg[MAG_W-1:0] : r[MAG_W-1:0];
    endfunction

    // configuration
    logic [MAG_W-1:0]         r_max_rate;
    logic [MHP_W-1:0]         r_min_hp;
    logic [1:0]               r_pol;

    // channel state
    logic signed [RATE_W-1:0] r_rate   [2];
    logic [HP_W-1:0]          r_hp_raw [2];
    logic [TIME_W-1:0]        r_ltt    [2];
    logic [1:0]               r_step;
    logic [1:0]               r_dir;
    logic                     r_enabled;
    logic [TIME_W-1:0]        r_now;

    // divider
    logic [HP_W-1:0]          r_rem;
    logic [HP_W-1:0]          r_dvs;
    logic [TIME_W-1:0]        r_dq;

    // output word
    logic [5:0]               r_out;

    logic signed [RATE_W-1:0] left_clamped;
    logic signed [RATE_W-1:0] right_clamped;
    logic signed [RATE_W-1:0] sel_rate;
    logic [TIME_W-1:0]        sel_ltt;
    logic [TIME_W-1:0]        ltt_eff;
    logic [TIME_W-1:0]        elapsed;
    logic                     behind;
    logic                     stopped;
    logic [MHP_W-1:0]         lo;
    logic [HP_W-1:0]          lo_x;
    logic [HP_W-1:0]          hp_eff;

    logic [HP_W:0]            t1;
    logic [HP_W:0]            t2;
    logic [HP_W:0]            d1;
    logic [HP_W:0]            d2;
    logic [HP_W:0]            dvs_x;
    logic [HP_W-1:0]          r1;
    logic [HP_W-1:0]          r2;
    logic                     q1;
    logic                     q2;

    assign left_clamped  = clamp_rate(i_left_rate, r_max_rate);
    assign right_clamped = clamp_rate(i_right_rate, r_max_rate);

    assign sel_rate = r_rate[i_cmd.ch];
    assign sel_ltt  = r_ltt[i_cmd.ch];
    // a zero toggle time starts the channel at the current tick
    assign ltt_eff  = (sel_ltt == '0) ? r_now : sel_ltt;
    assign behind   = r_now < ltt_eff;
    assign elapsed  = r_now - ltt_eff;
    assign stopped  = !r_enabled || (sel_rate == '0);

    assign lo     = (r_min_hp == '0) ? MHP_W'(1) : r_min_hp;
    assign lo_x   = {{(HP_W-MHP_W){1'b0}}, lo};
    assign hp_eff = (r_hp_raw[i_cmd.ch] < lo_x) ? lo_x : r_hp_raw[i_cmd.ch];

    assign o_stat.skip = i_cmd.op_time ? (stopped || behind) : (sel_rate == '0);

    // two restoring steps per cycle; remainder stays below the divisor
    always_comb begin
        dvs_x = {1'b0, r_dvs};
        t1    = {r_rem, r_dq[TIME_W-1]};
        d1    = t1 - dvs_x;
        q1    = t1 >= dvs_x;
        r1    = q1 ? d1[HP_W-1:0] : t1[HP_W-1:0];
        t2    = {r1, r_dq[TIME_W-2]};
        d2    = t2 - dvs_x;
        q2    = t2 >= dvs_x;
        r2    = q2 ? d2[HP_W-1:0] : t2[HP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate <= MAX_RATE_RST;
            r_min_hp   <= MIN_HP_RST;
            r_pol      <= 2'b11;
            r_rate[0]  <= '0;
            r_rate[1]  <= '0;
            r_ltt[0]   <= '0;
            r_ltt[1]   <= '0;
            r_step     <= '0;
            r_dir      <= '0;
            r_enabled  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_RATE:  r_max_rate <= i_cfg_data[MAG_W-1:0];
                    CFG_MIN_HP:    r_min_hp   <= i_cfg_data[MHP_W-1:0];
                    CFG_LEFT_POL:  r_pol[0]   <= i_cfg_data[0];
                    CFG_RIGHT_POL: r_pol[1]   <= i_cfg_data[0];
                    default:       ;
                endcase
            end
            if (i_cmd.accept) begin
                unique case (t_kind'(i_kind))
                    K_CMD: begin
                        r_rate[0] <= left_clamped;
                        r_rate[1] <= right_clamped;
                        r_dir     <= {~right_clamped[RATE_W-1], ~left_clamped[RATE_W-1]};
                    end
                    K_ENABLE: r_enabled <= i_enable_request;
                    default:  ;
                endcase
            end
            if (i_cmd.load && i_cmd.op_time) begin
                if (stopped) begin
                    r_step[i_cmd.ch] <= 1'b0;
                end else begin
                    r_ltt[i_cmd.ch] <= ltt_eff;
                end
            end
            if (i_cmd.store && i_cmd.op_time) begin
                // odd count flips the level; toggle time lands on the last whole period
                r_step[i_cmd.ch] <= r_step[i_cmd.ch] ^ r_dq[0];
                r_ltt[i_cmd.ch]  <= r_now - {{(TIME_W-HP_W){1'b0}}, r_rem};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (t_kind'(i_kind) == K_TICK)) begin
            r_now <= i_now_us;
        end
        if (i_cmd.load) begin
            r_rem <= '0;
            if (i_cmd.op_time) begin
                r_dvs <= hp_eff;
                r_dq  <= elapsed;
            end else begin
                r_dvs <= {{(HP_W-MAG_W){1'b0}}, rate_mag(sel_rate)};
                r_dq  <= {HP_NUM, {(TIME_W-HP_W){1'b0}}};
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= r2;
            r_dq  <= {r_dq[TIME_W-3:0], q1, q2};
        end
        if (i_cmd.store && !i_cmd.op_time) begin
            r_hp_raw[i_cmd.ch] <= r_dq[HP_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out <= {r_enabled ^ r_pol[1], r_enabled ^ r_pol[0], r_dir, r_step};
        end
    end

    assign o_left_step          = r_out[0];
    assign o_right_step         = r_out[1];
    assign o_left_dir           = r_out[2];
    assign o_right_dir          = r_out[3];
    assign o_left_enable_level  = r_out[4];
    assign o_right_enable_level = r_out[5];

endmodule

`default_nettype wire

// ===== rtl/dspg_ctrl.sv =====
// Controller: sequences each word through the per-channel divide passes and the output register.
`default_nettype none

module dspg_ctrl import dspg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_stat   i_stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_DIV   = 5'b00100,
        S_STORE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_ch;
    logic             n_ch;
    logic             r_op_time;
    logic             n_op_time;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;

    always_comb begin
        n_state       = r_state;
        n_ch          = r_ch;
        n_op_time     = r_op_time;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.ch      = r_ch;
        o_cmd.op_time = r_op_time;
        o_in_ready    = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_ch         = 1'b0;
                    n_op_time    = (t_kind'(i_kind) == K_TICK);
                    if ((t_kind'(i_kind) == K_TICK) || (t_kind'(i_kind) == K_CMD)) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_stat.skip) begin
                    n_ch    = 1'b1;
                    n_state = r_ch ? S_DONE : S_LOAD;
                end else begin
                    n_cnt   = r_op_time ? CNT_W'(TIME_PAIRS - 1) : CNT_W'(HP_PAIRS - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_ch        = 1'b1;
                n_state     = r_ch ? S_DONE : S_LOAD;
            end
            S_DONE: begin
                // wait here only while the previous word is still held
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 1'b0;
            r_op_time   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_op_time   <= n_op_time;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/dual_stepper_pulse_generator.sv =====
// Top level: step, direction and enable level generator for two stepper channels.
//
// Input channel (i_valid/o_ready) takes one word per item: a tick carrying the time
// in microseconds, a rate command with two signed rates, or an enable change.
// Output channel (o_valid/i_ready) returns one word per item with both channels'
// step, direction and polarity-adjusted enable levels after that item.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), used while idle.
// Work between input accept and output valid, with the output register free:
//   enable or unknown word: no divide
//   rate command: a half-period divide per nonzero-rate channel, zero-rate ones skipped
//   tick: an elapsed-time divide per running channel, stopped or not-yet-due ones skipped
// The cost is the single shared radix-4 divider, two quotient bits per cycle,
// over a 24-bit half-period quotient or a 48-bit elapsed-time quotient.
// A new word is taken while the previous result still waits in the output register;
// if the receiver stalls, the block holds its next result until the register frees.
// Synchronous active-low reset clears the rates, toggle times, step and direction levels,
// disables both channels and restores the configuration defaults; o_valid is low and o_ready high after reset.
`default_nettype none

module dual_stepper_pulse_generator import dspg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_kind,
    input  logic [TIME_W-1:0]        i_now_us,
    input  logic signed [RATE_W-1:0] i_left_rate,
    input  logic signed [RATE_W-1:0] i_right_rate,
    input  logic                     i_enable_request,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_left_step,
    output logic                     o_right_step,
    output logic                     o_left_dir,
    output logic                     o_right_dir,
    output logic                     o_left_enable_level,
    output logic                     o_right_enable_level,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    dspg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    dspg_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .o_stat               (dp_stat),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_kind               (i_kind),
        .i_now_us             (i_now_us),
        .i_left_rate          (i_left_rate),
        .i_right_rate         (i_right_rate),
        .i_enable_request     (i_enable_request),
        .o_left_step          (o_left_step),
        .o_right_step         (o_right_step),
        .o_left_dir           (o_left_dir),
        .o_right_dir          (o_right_dir),
        .o_left_enable_level  (o_left_enable_level),
        .o_right_enable_level (o_right_enable_level)
    );

endmodule

`default_nettype wire

// ===== rtl/dspg_chk.sv =====
// Port-level checker for the stepper pulse generator, bound to the top level.
`default_nettype none

module dspg_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic                     o_left_step,
    input logic                     o_right_step,
    input logic                     o_left_dir,
    input logic                     o_right_dir,
    input logic                     o_left_enable_level,
    input logic                     o_right_enable_level
);

    // leaving reset: ready for a word, nothing pending
    a_reset_idle: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (o_ready && !o_valid))
        else $error("not idle after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable({o_left_step, o_right_step,
            o_left_dir, o_right_dir, o_left_enable_level, o_right_enable_level})))
        else $error("output word changed while stalled");

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word taken while busy");

    // a fresh result only comes out of a busy cycle
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared without a finished word");

endmodule

bind dual_stepper_pulse_generator dspg_chk u_dspg_chk (.*);

`default_nettype wire

// ===== test/dspg_level_checker.sv =====
// Level checker: predicts step/dir/enable levels per accepted word and compares results.
`timescale 1ns / 100ps

module dspg_level_checker import dspg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_word_valid,
    input  logic                     i_word_ready,
    input  logic [1:0]               i_kind,
    input  logic [TIME_W-1:0]        i_now_us,
    input  logic signed [RATE_W-1:0] i_left_rate,
    input  logic signed [RATE_W-1:0] i_right_rate,
    input  logic                     i_enable_request,
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic                     i_left_step,
    input  logic                     i_right_step,
    input  logic                     i_left_dir,
    input  logic                     i_right_dir,
    input  logic                     i_left_enable_level,
    input  logic                     i_right_enable_level,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked
);

    localparam longint unsigned HALF_PERIOD_NUM = 64'd8_000_000;
    localparam int              MAX_PRINTED     = 50;

    typedef struct packed {
        logic left_step;
        logic right_step;
        logic left_dir;
        logic right_dir;
        logic left_enable_level;
        logic right_enable_level;
    } t_levels;

    // bit index order of t_levels, LSB first
    string level_names [6] = '{"right_enable_level", "left_enable_level", "right_dir",
                               "left_dir", "right_step", "left_step"};

    // shadow copy of channel state and registers
    logic signed [RATE_W-1:0] rate_q [2];
    logic [TIME_W-1:0]        last_q [2];
    logic                     step_q [2];
    logic                     dir_q  [2];
    logic                     en_q;
    logic [MAG_W-1:0]         max_rate_q;
    logic [MHP_W-1:0]         min_hp_q;
    logic                     lpol_q;
    logic                     rpol_q;

    t_levels expected_levels [$];
    int      err_count = 0;
    int      checked   = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTED)
            $display("ERROR: %s", msg);
        err_count++;
    endtask

    function automatic logic signed [RATE_W-1:0] clamp_rate(input logic signed [RATE_W-1:0] raw);
        longint value;
        longint limit;
        value = raw;
        limit = longint'(max_rate_q);
        if (value > limit)
            value = limit;
        if (value < -limit)
            value = -limit;
        return RATE_W'(value);
    endfunction

    // catch up one channel's step level to the tick time
    task automatic advance_channel(input int ch, input logic [TIME_W-1:0] now);
        longint          signed_rate;
        longint unsigned mag;
        longint unsigned half;
        longint unsigned floor_hp;
        longint unsigned elapsed;
        longint unsigned toggles;
        signed_rate = rate_q[ch];
        if (!en_q || signed_rate == 0) begin
            step_q[ch] = 1'b0;
            return;
        end
        mag = (signed_rate < 0) ? -signed_rate : signed_rate;
        half = HALF_PERIOD_NUM / mag;
        floor_hp = (min_hp_q == '0) ? 64'd1 : 64'(min_hp_q);
        if (half < floor_hp)
            half = floor_hp;
        if (last_q[ch] == '0)
            last_q[ch] = now;
        if (now < last_q[ch])
            return;
        elapsed = 64'(now) - 64'(last_q[ch]);
        toggles = elapsed / half;
        step_q[ch] = step_q[ch] ^ toggles[0];
        last_q[ch] = TIME_W'(64'(last_q[ch]) + toggles * half);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_levels want;
        t_levels seen;
        if (!i_rst_n) begin
            max_rate_q = MAX_RATE_RST;
            min_hp_q   = MIN_HP_RST;
            lpol_q     = 1'b1;
            rpol_q     = 1'b1;
            for (int c = 0; c < 2; c++) begin
                rate_q[c] = '0;
                last_q[c] = '0;
                step_q[c] = 1'b0;
                dir_q[c]  = 1'b0;
            end
            en_q = 1'b0;
            expected_levels.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_RATE:  max_rate_q = i_cfg_data[MAG_W-1:0];
                    CFG_MIN_HP:    min_hp_q   = i_cfg_data[MHP_W-1:0];
                    CFG_LEFT_POL:  lpol_q     = i_cfg_data[0];
                    CFG_RIGHT_POL: rpol_q     = i_cfg_data[0];
                    default: ;
                endcase
            end

            // results leave before a word accepted on the same edge can produce one
            if (i_res_valid && i_res_ready) begin
                seen = {i_left_step, i_right_step, i_left_dir, i_right_dir,
                        i_left_enable_level, i_right_enable_level};
                if (expected_levels.size() == 0) begin
                    report_error($sformatf("result %0d arrived with no word outstanding",
                                           checked));
                end else begin
                    want = expected_levels.pop_front();
                    for (int b = 0; b < 6; b++) begin
                        if (seen[b] !== want[b])
                            report_error($sformatf("result %0d %s expected %0b got %0b",
                                                   checked, level_names[b], want[b], seen[b]));
                    end
                end
                checked++;
            end

            if (i_word_valid && i_word_ready) begin
                case (t_kind'(i_kind))
                    K_TICK: begin
                        advance_channel(0, i_now_us);
                        advance_channel(1, i_now_us);
                    end
                    K_CMD: begin
                        rate_q[0] = clamp_rate(i_left_rate);
                        rate_q[1] = clamp_rate(i_right_rate);
                        dir_q[0]  = ~rate_q[0][RATE_W-1];
                        dir_q[1]  = ~rate_q[1][RATE_W-1];
                    end
                    K_ENABLE: en_q = i_enable_request;
                    default: ;
                endcase
                want = {step_q[0], step_q[1], dir_q[0], dir_q[1], en_q ^ lpol_q, en_q ^ rpol_q};
                expected_levels.push_back(want);
            end
        end
        o_pending <= expected_levels.size();
        o_errors  <= err_count;
        o_checked <= checked;
    end

endmodule

// ===== test/dual_stepper_pulse_generator_tb.sv =====
// Testbench top: word stimulus, result back-pressure, register settings and the verdict.
`timescale 1ns / 100ps

module dual_stepper_pulse_generator_tb;
    import dspg_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_WORDS = 250;
    localparam int PHASES      = 7;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_valid          = 1'b0;
    logic [1:0]               i_kind           = '0;
    logic [TIME_W-1:0]        i_now_us         = '0;
    logic signed [RATE_W-1:0] i_left_rate      = '0;
    logic signed [RATE_W-1:0] i_right_rate     = '0;
    logic                     i_enable_request = 1'b0;
    logic                     i_ready          = 1'b0;
    logic                     i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx        = '0;
    logic [CFG_W-1:0]         i_cfg_data       = '0;

    logic o_ready;
    logic o_valid;
    logic o_left_step;
    logic o_right_step;
    logic o_left_dir;
    logic o_right_dir;
    logic o_left_enable_level;
    logic o_right_enable_level;

    int checker_errors;
    int checker_pending;
    int checker_checked;

    // stimulus bookkeeping
    bit                bursts_on   = 1'b1;
    bit                enable_sent = 1'b0;
    int                words_sent  = 0;
    int                kind_count [4] = '{0, 0, 0, 0};
    int                settings_applied = 0;
    int                quiet_cycles = 0;
    int                phase;
    int                phase_start;
    logic [MAG_W-1:0]  max_rate_set = MAX_RATE_RST;
    logic [MHP_W-1:0]  min_hp_set   = MIN_HP_RST;
    logic [TIME_W-1:0] cur_now;
    logic [TIME_W-1:0] tick_now;

    dual_stepper_pulse_generator u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_kind               (i_kind),
        .i_now_us             (i_now_us),
        .i_left_rate          (i_left_rate),
        .i_right_rate         (i_right_rate),
        .i_enable_request     (i_enable_request),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_left_step          (o_left_step),
        .o_right_step         (o_right_step),
        .o_left_dir           (o_left_dir),
        .o_right_dir          (o_right_dir),
        .o_left_enable_level  (o_left_enable_level),
        .o_right_enable_level (o_right_enable_level),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data)
    );

    dspg_level_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_word_valid         (i_valid),
        .i_word_ready         (o_ready),
        .i_kind               (i_kind),
        .i_now_us             (i_now_us),
        .i_left_rate          (i_left_rate),
        .i_right_rate         (i_right_rate),
        .i_enable_request     (i_enable_request),
        .i_res_valid          (o_valid),
        .i_res_ready          (i_ready),
        .i_left_step          (o_left_step),
        .i_right_step         (o_right_step),
        .i_left_dir           (o_left_dir),
        .i_right_dir          (o_right_dir),
        .i_left_enable_level  (o_left_enable_level),
        .i_right_enable_level (o_right_enable_level),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_errors             (checker_errors),
        .o_pending            (checker_pending),
        .o_checked            (checker_checked)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TIMEOUT: no handshake for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (bursts_on && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    task automatic send_word(input t_kind kind, input logic [TIME_W-1:0] now,
                             input logic signed [RATE_W-1:0] left_rate,
                             input logic signed [RATE_W-1:0] right_rate,
                             input logic en);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_kind           <= kind;
        i_now_us         <= now;
        i_left_rate      <= left_rate;
        i_right_rate     <= right_rate;
        i_enable_request <= en;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        kind_count[kind]++;
    endtask

    // unused fields carry random bits
    task automatic send_tick(input logic [TIME_W-1:0] now);
        send_word(K_TICK, now, RATE_W'($urandom), RATE_W'($urandom), 1'($urandom));
    endtask

    task automatic send_cmd(input logic signed [RATE_W-1:0] left_rate,
                            input logic signed [RATE_W-1:0] right_rate);
        send_word(K_CMD, TIME_W'({$urandom, $urandom}), left_rate, right_rate, 1'($urandom));
    endtask

    task automatic send_enable(input logic en);
        send_word(K_ENABLE, TIME_W'({$urandom, $urandom}), RATE_W'($urandom),
                  RATE_W'($urandom), en);
        enable_sent = en;
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (checker_pending != 0);
    endtask

    task automatic apply_setting(input logic [MAG_W-1:0] max_rate,
                                 input logic [MHP_W-1:0] min_hp,
                                 input logic left_pol, input logic right_pol);
        wait_results_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_RATE;
        i_cfg_data <= CFG_W'(max_rate);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIN_HP;
        i_cfg_data <= CFG_W'(min_hp);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LEFT_POL;
        i_cfg_data <= CFG_W'(left_pol);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RIGHT_POL;
        i_cfg_data <= CFG_W'(right_pol);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        max_rate_set = max_rate;
        min_hp_set   = min_hp;
        settings_applied++;
    endtask

    function automatic logic signed [RATE_W-1:0] pick_rate();
        logic signed [RATE_W-1:0] mag;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return RATE_W'($urandom);
            2: mag = RATE_W'(max_rate_set);
            3, 4: mag = RATE_W'($urandom_range(1, 200));
            default: mag = RATE_W'($urandom_range(8000, 400000));
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults after reset
        send_word(K_NONE, TIME_W'({$urandom, $urandom}), RATE_W'($urandom),
                  RATE_W'($urandom), 1'($urandom));
        send_tick('0);
        send_enable(1'b1);
        send_cmd('0, '0);
        send_tick(48'd50);
        send_cmd(21'sh0F_FFFF, 21'sh10_0000);   // clamp to 80000 and -80000
        send_tick(48'd1000);                    // first tick seeds last toggle time
        send_tick(48'd1099);
        send_tick(48'd1100);
        send_tick(48'd1350);                    // two half periods at once
        send_tick(48'd700);                     // time behind last toggle
        send_enable(1'b0);
        send_tick(48'hFFFF_FFFF_FFFF);          // disabled: forced low, time kept
        send_enable(1'b1);
        send_tick(48'd104_859_999);             // long catch-up
        send_cmd(21'sd1, -21'sd1);
        send_word(K_NONE, TIME_W'({$urandom, $urandom}), RATE_W'($urandom),
                  RATE_W'($urandom), 1'($urandom));

        // zero clamp, zero minimum half period, mixed polarity
        apply_setting('0, '0, 1'b0, 1'b1);
        send_cmd(RATE_W'($urandom), RATE_W'($urandom));
        send_tick(48'd200_000_000);

        apply_setting('1, '1, 1'b1, 1'b0);
        send_cmd(21'sh0F_FFFF, 21'sh10_0000);
        send_tick(48'd300_000_000);
        send_tick(48'd300_065_535);

        apply_setting('1, 16'd1, 1'b0, 1'b0);
        send_tick(48'd300_065_540);
        send_tick(48'd300_100_000);
        cur_now = 48'd300_200_000;

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES - 1)
                bursts_on = 1'b0;
            case (phase)
                0: apply_setting(MAX_RATE_RST, MIN_HP_RST, 1'b1, 1'b1);
                1: apply_setting('1, 16'd1, 1'b0, 1'b0);
                3: apply_setting('1, '1, 1'b1, 1'b1);
                6: apply_setting(MAX_RATE_RST, MIN_HP_RST, 1'b0, 1'b1);
                default: apply_setting(MAG_W'($urandom_range(1000, 300000)),
                                       MHP_W'($urandom_range(1, 2000)),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            // move the time base into the upper half of the counter
            if (phase == 4)
                cur_now = 48'h8000_0000_0000 | TIME_W'({$urandom, $urandom} >> 19);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                case ($urandom_range(0, 9))
                    0: begin
                        tick_now = cur_now - (TIME_W'({$urandom, $urandom}) % (cur_now + 1));
                        send_word(t_kind'($urandom_range(0, 3)), tick_now, RATE_W'($urandom),
                                  RATE_W'($urandom), 1'($urandom));
                    end
                    1: send_enable($urandom_range(0, 2) != 0);
                    default: begin
                        if (!enable_sent || $urandom_range(0, 7) == 0)
                            send_enable(1'b1);
                        send_cmd(pick_rate(), pick_rate());
                        repeat ($urandom_range(3, 30)) begin
                            case ($urandom_range(0, 19))
                                0: tick_now = cur_now -
                                        (TIME_W'({$urandom, $urandom}) % (cur_now + 1));
                                1: begin
                                    cur_now = cur_now +
                                        TIME_W'({$urandom, $urandom} >> $urandom_range(26, 56));
                                    tick_now = cur_now;
                                end
                                2, 3, 4, 5, 6: begin
                                    cur_now = cur_now +
                                        TIME_W'($urandom_range(1, 3 * min_hp_set + 200));
                                    tick_now = cur_now;
                                end
                                default: begin
                                    cur_now = cur_now + TIME_W'($urandom_range(1, 40));
                                    tick_now = cur_now;
                                end
                            endcase
                            send_tick(tick_now);
                        end
                    end
                endcase
                // sender holds off until the result side is empty
                if ($urandom_range(0, 39) == 0)
                    wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d words: %0d ticks, %0d rate commands, %0d enable changes, %0d unknown",
                 words_sent, kind_count[K_TICK], kind_count[K_CMD], kind_count[K_ENABLE],
                 kind_count[K_NONE]);
        $display("Checked %0d results over %0d register settings, %0d mismatches",
                 checker_checked, settings_applied, checker_errors);
        if (checker_errors == 0 && checker_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
